// ===== rtl/crrl_pkg.sv =====
package crrl_pkg;

    localparam logic [2:0] FN_WRITE   = 3'd0;
    localparam logic [2:0] FN_RD_TAIL = 3'd1;
    localparam logic [2:0] FN_RD_POS  = 3'd2;
    localparam logic [2:0] FN_DELETE  = 3'd3;
    localparam logic [2:0] FN_FORMAT  = 3'd4;

    localparam logic [2:0] STS_OK    = 3'd0;
    localparam logic [2:0] STS_FULL  = 3'd1;
    localparam logic [2:0] STS_EMPTY = 3'd2;
    localparam logic [2:0] STS_CKSUM = 3'd3;
    localparam logic [2:0] STS_TAG   = 3'd4;
    localparam logic [2:0] STS_OVF   = 3'd5;

    localparam logic [4:0] READ_MAX = 5'd30;
    localparam logic [7:0] ERASED   = 8'hFF;
    localparam logic [7:0] TAG_INIT = 8'd170;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_WR_PAD,
        S_WR_CK,
        S_WR_TAG,
        S_POS_MOD,
        S_CHK,
        S_CHK_END,
        S_VERDICT,
        S_EM_READ,
        S_EM_OUT,
        S_DEL_CHECK,
        S_DEL_ERASE,
        S_FMT_ERASE,
        S_RESP
    } ctl_state_t;

    typedef struct packed {
        logic [2:0]        func;
        logic [7:0]        data_byte;
        logic              last_byte;
        logic [4:0]        byte_count;
        logic [7:0]        position;
        logic signed [9:0] delete_count;
        logic              full_erase;
    } item_t;

    typedef struct packed {
        logic       take_item;
        logic       wr_byte;
        logic       wr_pad;
        logic       wr_ck;
        logic       wr_tag;
        logic       set_status;
        logic [2:0] status_val;
        logic       rd_tail;
        logic       pos_reduce;
        logic       pos_to_slot;
        logic       chk_read;
        logic       verdict;
        logic       em_read;
        logic       em_load;
        logic       resp_load;
        logic       del_start;
        logic       del_erase;
        logic       del_pop;
        logic       fmt;
        logic       sweep;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       last_byte;
        logic       full_erase;
        logic       full;
        logic       empty;
        logic       fill_done;
        logic       last_off;
        logic       em_last;
        logic       pos_big;
        logic       del_done;
        logic       sweep_last;
        logic       out_free;
    } dp_status_t;

endpackage

// ===== rtl/crrl_if.sv =====
interface crrl_item_if;
    logic              valid;
    logic              ready;
    logic [2:0]        func;
    logic [7:0]        data_byte;
    logic              last_byte;
    logic [4:0]        byte_count;
    logic [7:0]        position;
    logic signed [9:0] delete_count;
    logic              full_erase;

    modport source (
        output valid, func, data_byte, last_byte, byte_count, position, delete_count,
               full_erase,
        input  ready
    );
    modport sink (
        input  valid, func, data_byte, last_byte, byte_count, position, delete_count,
               full_erase,
        output ready
    );
endinterface

interface crrl_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;
    logic [8:0] records_held;

    modport source (
        output valid, out_byte, status, last, records_held,
        input  ready
    );
    modport sink (
        input  valid, out_byte, status, last, records_held,
        output ready
    );
endinterface

// ===== rtl/crrl_dp.sv =====
module crrl_dp
    import crrl_pkg::*;
#(
    parameter int RECORD_BYTES = 32,
    parameter int MAX_RECORDS  = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      item,
    input  logic       tag_we,
    input  logic [7:0] tag_wdata,
    input  dp_cmd_t    cmd,
    output dp_status_t st,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [2:0] out_status,
    output logic       out_last,
    output logic [8:0] out_held
);

    localparam int STORE = RECORD_BYTES * MAX_RECORDS;
    localparam int AW    = $clog2(STORE);
    localparam int SW    = $clog2(MAX_RECORDS);
    localparam int HW    = $clog2(MAX_RECORDS + 1);
    localparam int OW    = $clog2(RECORD_BYTES);
    localparam int DLW   = (HW > 9) ? HW : 9;

    localparam logic [OW-1:0]  OFF_CK    = OW'(RECORD_BYTES - 2);
    localparam logic [OW-1:0]  OFF_TAG   = OW'(RECORD_BYTES - 1);
    localparam logic [SW-1:0]  SLOT_LAST = SW'(MAX_RECORDS - 1);
    localparam logic [HW-1:0]  HELD_MAX  = HW'(MAX_RECORDS);
    localparam logic [AW-1:0]  ADDR_LAST = AW'(STORE - 1);
    localparam logic [AW-1:0]  RB_A      = AW'(RECORD_BYTES);
    localparam logic [7:0]     POS_SUB   = 8'(MAX_RECORDS);

    logic [7:0]     mem [STORE];
    logic [7:0]     rdata_reg;
    logic           mem_we;
    logic           mem_re;
    logic [7:0]     mem_wdata;
    logic [AW-1:0]  mem_addr;
    logic [SW-1:0]  slot_sel;
    logic [OW-1:0]  off_sel;
    logic           use_sweep;

    logic [7:0]     tag_reg;
    logic [SW-1:0]  head_reg;
    logic [SW-1:0]  tail_reg;
    logic [HW-1:0]  held_reg;
    logic [OW-1:0]  fill_reg;
    logic [7:0]     wsum_reg;
    logic [AW-1:0]  sweep_reg;
    logic           rd_pend_reg;
    logic           out_valid_reg;

    logic [2:0]     func_reg;
    logic [7:0]     data_reg;
    logic           last_reg;
    logic [9:0]     dcount_reg;
    logic           erase_reg;
    logic [4:0]     n_reg;
    logic [7:0]     pos_reg;
    logic [SW-1:0]  rd_slot_reg;
    logic [OW-1:0]  cnt_reg;
    logic [OW-1:0]  rd_off_reg;
    logic [7:0]     chk_sum_reg;
    logic [7:0]     ck_reg;
    logic [7:0]     tg_reg;
    logic [DLW-1:0] del_left_reg;
    logic [2:0]     status_reg;
    logic [7:0]     out_byte_reg;
    logic [2:0]     out_status_reg;
    logic           out_last_reg;
    logic [8:0]     out_held_reg;

    logic [4:0]     n_clamp;
    logic [2:0]     verdict_sts;
    logic           room;
    logic [SW-1:0]  head_next;
    logic [SW-1:0]  tail_next;

    assign room      = fill_reg < OFF_CK;
    assign head_next = (head_reg == SLOT_LAST) ? '0 : head_reg + 1'b1;
    assign tail_next = (tail_reg == SLOT_LAST) ? '0 : tail_reg + 1'b1;

    always_comb
    begin
        n_clamp = item.byte_count;
        if (n_clamp == 5'd0)
        begin
            n_clamp = 5'd1;
        end
        if (n_clamp > READ_MAX)
        begin
            n_clamp = READ_MAX;
        end
        if (RECORD_BYTES < 30 && int'(n_clamp) > RECORD_BYTES)
        begin
            n_clamp = 5'(RECORD_BYTES);
        end
    end

    always_comb
    begin
        if (ck_reg != ~chk_sum_reg)
        begin
            verdict_sts = STS_CKSUM;
        end
        else if (tg_reg != tag_reg)
        begin
            verdict_sts = STS_TAG;
        end
        else
        begin
            verdict_sts = STS_OK;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = ERASED;
        slot_sel  = head_reg;
        off_sel   = fill_reg;
        use_sweep = 1'b0;
        priority if (cmd.sweep)
        begin
            mem_we    = 1'b1;
            use_sweep = 1'b1;
        end
        else if (cmd.wr_byte)
        begin
            mem_we    = room;
            mem_wdata = data_reg;
        end
        else if (cmd.wr_pad)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.wr_ck)
        begin
            mem_we    = 1'b1;
            off_sel   = OFF_CK;
            mem_wdata = ~wsum_reg;
        end
        else if (cmd.wr_tag)
        begin
            mem_we    = 1'b1;
            off_sel   = OFF_TAG;
            mem_wdata = tag_reg;
        end
        else if (cmd.chk_read || cmd.em_read)
        begin
            mem_re   = 1'b1;
            slot_sel = rd_slot_reg;
            off_sel  = cnt_reg;
        end
        else if (cmd.del_erase)
        begin
            mem_we   = 1'b1;
            slot_sel = tail_reg;
            off_sel  = cnt_reg;
        end
        else
        begin
            mem_we = 1'b0;
        end
        mem_addr = use_sweep ? sweep_reg : AW'(slot_sel) * RB_A + AW'(off_sel);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg       <= TAG_INIT;
            head_reg      <= '0;
            tail_reg      <= '0;
            held_reg      <= '0;
            fill_reg      <= '0;
            wsum_reg      <= '0;
            sweep_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tag_we)
            begin
                tag_reg <= tag_wdata;
            end
            if (cmd.sweep)
            begin
                sweep_reg <= (sweep_reg == ADDR_LAST) ? '0 : sweep_reg + 1'b1;
            end
            if (cmd.wr_byte && room)
            begin
                fill_reg <= fill_reg + 1'b1;
                wsum_reg <= wsum_reg + data_reg;
            end
            if (cmd.wr_pad)
            begin
                fill_reg <= fill_reg + 1'b1;
                wsum_reg <= wsum_reg + ERASED;
            end
            if (cmd.wr_tag)
            begin
                held_reg <= held_reg + 1'b1;
                head_reg <= head_next;
                fill_reg <= '0;
                wsum_reg <= '0;
            end
            if ((cmd.verdict && func_reg == FN_RD_TAIL && verdict_sts == STS_OK) ||
                cmd.del_pop)
            begin
                held_reg <= held_reg - 1'b1;
                tail_reg <= tail_next;
            end
            if (cmd.fmt)
            begin
                head_reg <= '0;
                tail_reg <= '0;
                held_reg <= '0;
                fill_reg <= '0;
                wsum_reg <= '0;
            end
            rd_pend_reg <= cmd.chk_read;
            if (cmd.em_load || cmd.resp_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            func_reg   <= item.func;
            data_reg   <= item.data_byte;
            last_reg   <= item.last_byte;
            dcount_reg <= item.delete_count;
            erase_reg  <= item.full_erase;
            n_reg      <= n_clamp;
            pos_reg    <= item.position;
        end
        if (cmd.pos_reduce)
        begin
            pos_reg <= pos_reg - POS_SUB;
        end
        if (cmd.pos_to_slot || cmd.rd_tail)
        begin
            rd_slot_reg <= cmd.rd_tail ? tail_reg : SW'(pos_reg);
            cnt_reg     <= '0;
            chk_sum_reg <= '0;
        end
        if (cmd.chk_read)
        begin
            cnt_reg    <= cnt_reg + 1'b1;
            rd_off_reg <= cnt_reg;
        end
        if (rd_pend_reg)
        begin
            if (rd_off_reg < OFF_CK)
            begin
                chk_sum_reg <= chk_sum_reg + rdata_reg;
            end
            else if (rd_off_reg == OFF_CK)
            begin
                ck_reg <= rdata_reg;
            end
            else
            begin
                tg_reg <= rdata_reg;
            end
        end
        if (cmd.verdict)
        begin
            status_reg <= verdict_sts;
            cnt_reg    <= '0;
        end
        if (cmd.del_start)
        begin
            cnt_reg      <= '0;
            del_left_reg <= dcount_reg[9] ? DLW'(held_reg) : DLW'(dcount_reg[8:0]);
        end
        if (cmd.del_erase)
        begin
            cnt_reg <= (cnt_reg == OFF_TAG) ? '0 : cnt_reg + 1'b1;
        end
        if (cmd.del_pop)
        begin
            del_left_reg <= del_left_reg - 1'b1;
        end
        if (cmd.wr_byte)
        begin
            status_reg <= room ? STS_OK : STS_OVF;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_val;
        end
        if (cmd.em_load)
        begin
            cnt_reg        <= cnt_reg + 1'b1;
            out_byte_reg   <= rdata_reg;
            out_status_reg <= status_reg;
            out_last_reg   <= st.em_last;
            out_held_reg   <= 9'(held_reg);
        end
        if (cmd.resp_load)
        begin
            out_byte_reg   <= 8'h00;
            out_status_reg <= status_reg;
            out_last_reg   <= 1'b1;
            out_held_reg   <= 9'(held_reg);
        end
    end

    always_comb
    begin
        st.func       = func_reg;
        st.last_byte  = last_reg;
        st.full_erase = erase_reg;
        st.full       = (held_reg == HELD_MAX);
        st.empty      = (held_reg == '0);
        st.fill_done  = !room;
        st.last_off   = (cnt_reg == OFF_TAG);
        st.em_last    = ((int'(cnt_reg) + 1) == int'(n_reg));
        st.pos_big    = (int'(pos_reg) >= MAX_RECORDS);
        st.del_done   = (del_left_reg == '0) || (held_reg == '0);
        st.sweep_last = (sweep_reg == ADDR_LAST);
        st.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;
    assign out_held   = out_held_reg;

endmodule

// ===== rtl/crrl_ctrl.sv =====
module crrl_ctrl
    import crrl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (st.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (st.func)
                    FN_WRITE:
                    begin
                        if (st.full || !st.last_byte)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            state_next = S_WR_PAD;
                        end
                    end
                    FN_RD_TAIL: state_next = st.empty ? S_RESP : S_CHK;
                    FN_RD_POS:  state_next = S_POS_MOD;
                    FN_DELETE:  state_next = S_DEL_CHECK;
                    FN_FORMAT:  state_next = st.full_erase ? S_FMT_ERASE : S_RESP;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_WR_PAD:
            begin
                if (st.fill_done)
                begin
                    state_next = S_WR_CK;
                end
            end
            S_WR_CK:   state_next = S_WR_TAG;
            S_WR_TAG:  state_next = S_RESP;
            S_POS_MOD:
            begin
                if (!st.pos_big)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (st.last_off)
                begin
                    state_next = S_CHK_END;
                end
            end
            S_CHK_END: state_next = S_VERDICT;
            S_VERDICT: state_next = S_EM_READ;
            S_EM_READ: state_next = S_EM_OUT;
            S_EM_OUT:
            begin
                if (st.out_free)
                begin
                    state_next = st.em_last ? S_IDLE : S_EM_READ;
                end
            end
            S_DEL_CHECK: state_next = st.del_done ? S_RESP : S_DEL_ERASE;
            S_DEL_ERASE:
            begin
                if (st.last_off)
                begin
                    state_next = S_DEL_CHECK;
                end
            end
            S_FMT_ERASE:
            begin
                if (st.sweep_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep = 1'b1;
            end
            S_IDLE:
            begin
                item_ready    = 1'b1;
                cmd.take_item = item_valid;
            end
            S_DECODE:
            begin
                unique case (st.func)
                    FN_WRITE:
                    begin
                        if (st.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = STS_FULL;
                        end
                        else
                        begin
                            cmd.wr_byte = 1'b1;
                        end
                    end
                    FN_RD_TAIL:
                    begin
                        if (st.empty)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = STS_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_tail = 1'b1;
                        end
                    end
                    FN_RD_POS: cmd = '0;
                    FN_DELETE:
                    begin
                        cmd.del_start = 1'b1;
                    end
                    FN_FORMAT:
                    begin
                        cmd.fmt        = 1'b1;
                        cmd.set_status = 1'b1;
                        cmd.status_val = STS_OK;
                    end
                    default: cmd = '0;
                endcase
            end
            S_WR_PAD:
            begin
                cmd.wr_pad = !st.fill_done;
            end
            S_WR_CK:
            begin
                cmd.wr_ck = 1'b1;
            end
            S_WR_TAG:
            begin
                cmd.wr_tag = 1'b1;
            end
            S_POS_MOD:
            begin
                cmd.pos_reduce  = st.pos_big;
                cmd.pos_to_slot = !st.pos_big;
            end
            S_CHK:
            begin
                cmd.chk_read = 1'b1;
            end
            S_CHK_END: cmd = '0;
            S_VERDICT:
            begin
                cmd.verdict = 1'b1;
            end
            S_EM_READ:
            begin
                cmd.em_read = 1'b1;
            end
            S_EM_OUT:
            begin
                cmd.em_load = st.out_free;
            end
            S_DEL_CHECK:
            begin
                cmd.set_status = st.del_done;
                cmd.status_val = STS_OK;
            end
            S_DEL_ERASE:
            begin
                cmd.del_erase = 1'b1;
                cmd.del_pop   = st.last_off;
            end
            S_FMT_ERASE:
            begin
                cmd.sweep = 1'b1;
            end
            S_RESP:
            begin
                cmd.resp_load = st.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

// ===== rtl/checksummed_record_ring_log.sv =====
// A write byte presents its result after acceptance, and the next transaction is accepted once
// that result is loaded; the last byte of a record also writes 0xFF padding, checksum and tag.
// A read tail makes a checksum pass over the record in the one-port memory (a read at a position
// first brings it below MAX_RECORDS), then returns bytes one by one; a delete erases records bytewise.
// Reset clears the pointers at once, then a pass writes 0xFF to all RECORD_BYTES*MAX_RECORDS
// bytes before the first transaction; format with erase does the same.
module checksummed_record_ring_log
    import crrl_pkg::*;
#(
    parameter int RECORD_BYTES = 32,
    parameter int MAX_RECORDS  = 256
)
(
    input  logic          clk,
    input  logic          rst_n,
    crrl_item_if.sink     item_ch,
    crrl_result_if.source result_ch,
    input  logic          tag_we,
    input  logic [7:0]    tag_wdata
);

    item_t      item;
    dp_cmd_t    dp_cmd;
    dp_status_t dp_st;

    always_comb
    begin
        item.func         = item_ch.func;
        item.data_byte    = item_ch.data_byte;
        item.last_byte    = item_ch.last_byte;
        item.byte_count   = item_ch.byte_count;
        item.position     = item_ch.position;
        item.delete_count = item_ch.delete_count;
        item.full_erase   = item_ch.full_erase;
    end

    crrl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_ch.valid),
        .item_ready (item_ch.ready),
        .st         (dp_st),
        .cmd        (dp_cmd)
    );

    crrl_dp #(
        .RECORD_BYTES (RECORD_BYTES),
        .MAX_RECORDS  (MAX_RECORDS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .tag_we     (tag_we),
        .tag_wdata  (tag_wdata),
        .cmd        (dp_cmd),
        .st         (dp_st),
        .out_valid  (result_ch.valid),
        .out_ready  (result_ch.ready),
        .out_byte   (result_ch.out_byte),
        .out_status (result_ch.status),
        .out_last   (result_ch.last),
        .out_held   (result_ch.records_held)
    );

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (item_ch.valid && item_ch.ready) |=> !item_ch.ready)
        else $error("Input still ready in the cycle after a transaction was accepted.");

    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(dp_st.full && dp_st.empty))
        else $error("Log reported full and empty at the same time.");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_ch.valid && result_ch.status == STS_FULL) |->
        (result_ch.out_byte == 8'h00 && result_ch.last))
        else $error("A refused write produced a data byte or a multi-part result.");

endmodule
